/* design/wsas_pkg.sv */
package wsas_pkg;

  localparam int MAX_WAYPOINTS_DEF = 64;
  localparam int COORD_WIDTH_DEF   = 24;
  localparam int RAD_W             = 23;
  localparam int FORCE_W           = 26;
  localparam int IDX_W             = 6;
  localparam int REQ_W             = 2;
  localparam int CFG_IDX_W         = 2;

  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STEP   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ARRIVE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REACH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd2;

  localparam logic [RAD_W-1:0] ARRIVE_RST = 23'd16384;
  localparam logic [RAD_W-1:0] REACH_RST  = 23'd4352;
  localparam logic [RAD_W-1:0] GAIN_RST   = 23'd25600;

endpackage

/* design/wsas_if.sv */
interface wsas_in_if #(parameter int COORD_WIDTH = wsas_pkg::COORD_WIDTH_DEF);
  logic                          valid;
  logic                          ready;
  logic [wsas_pkg::REQ_W-1:0]    req_type;
  logic signed [COORD_WIDTH-1:0] waypoint_x;
  logic signed [COORD_WIDTH-1:0] waypoint_y;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] vel_x;
  logic signed [COORD_WIDTH-1:0] vel_y;
  logic [wsas_pkg::RAD_W-1:0]    max_speed;
  modport source (output valid, req_type, waypoint_x, waypoint_y, pos_x, pos_y, vel_x,
                  vel_y, max_speed, input ready);
  modport sink (input valid, req_type, waypoint_x, waypoint_y, pos_x, pos_y, vel_x,
                vel_y, max_speed, output ready);
endinterface

interface wsas_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [wsas_pkg::FORCE_W-1:0] force_x;
  logic signed [wsas_pkg::FORCE_W-1:0] force_y;
  logic                                has_path;
  logic [wsas_pkg::IDX_W-1:0]          waypoint_index;
  modport source (output valid, force_x, force_y, has_path, waypoint_index, input ready);
  modport sink (input valid, force_x, force_y, has_path, waypoint_index, output ready);
endinterface

/* design/waypoint_seek_arrive_steering_unit.sv */
// Clear and append update the path on acceptance and give no result; a step on an empty path
// has its result in the cycle after acceptance, and any other step once one shared bit-serial
// unit has run up to two square roots of 26 steps and up to six divisions of 52 steps.
// One item at a time: the next item is accepted in the cycle after the result leaves.
// Reset (rst_n, synchronous, active low) empties the path, zeroes the index and
// loads the register defaults; waypoint memory contents stay undefined.
module waypoint_seek_arrive_steering_unit #(
  parameter int MAX_WAYPOINTS = wsas_pkg::MAX_WAYPOINTS_DEF,
  parameter int COORD_WIDTH   = wsas_pkg::COORD_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  wsas_in_if.sink                            in_ch,
  wsas_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [wsas_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wsas_pkg::RAD_W-1:0]         cfg_data
);
  localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int LW = $clog2(MAX_WAYPOINTS + 1);
  localparam int QW = (COORD_WIDTH + 1 > wsas_pkg::RAD_W + 2) ? COORD_WIDTH + 1
                                                               : wsas_pkg::RAD_W + 2;
  localparam int W  = 2 * QW + 2;
  localparam int SQ = W / 2;
  localparam int FW = wsas_pkg::FORCE_W;
  localparam int IW = wsas_pkg::IDX_W;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_DIFF, S_SQ1, S_CHK, S_DIVX, S_DIVY, S_SUBV, S_SQ2, S_NDX, S_NDY,
    S_ADX, S_ADY, S_ADE, S_FIN, S_OUT
  } state_t;

  state_t state_r;
  logic [2*COORD_WIDTH-1:0] mem_r [MAX_WAYPOINTS];
  logic [2*COORD_WIDTH-1:0] rd_r;
  logic [LW-1:0] len_r;
  logic [AW-1:0] idx_r;
  logic [wsas_pkg::RAD_W-1:0] arrive_r, reach_r, gain_r, ms_r;
  logic signed [W-1:0] px_r, py_r, vx_r, vy_r, dx_r, dy_r, fx_r, fy_r;
  logic [W-1:0] dist_r, fmag_r;
  logic [W-1:0] num_r, rem_r, acc_r, den_r;
  logic [6:0] cnt_r;
  logic busy_r, neg_r;
  logic signed [FW-1:0] ox_r, oy_r;
  logic ohas_r, ovalid_r;
  logic [IW-1:0] oidx_r;

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] a);
    return a[W-1] ? W'(-a) : W'(a);
  endfunction

  function automatic logic signed [FW-1:0] sat(input logic signed [W-1:0] v);
    if (v > W'(signed'((1 << (FW - 1)) - 1))) return FW'((1 << (FW - 1)) - 1);
    else if (v < -W'(signed'(1 << (FW - 1)))) return FW'(1 << (FW - 1));
    else return v[FW-1:0];
  endfunction

  logic in_fire, out_fire;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = ovalid_r;
  assign out_ch.force_x = ox_r;
  assign out_ch.force_y = oy_r;
  assign out_ch.has_path = ohas_r;
  assign out_ch.waypoint_index = oidx_r;

  // Shared unit step: square root (2 bits/step) or restoring divide (1 bit/step).
  logic [W-1:0] trial, rem_sh, sqt;
  logic [W+1:0] sq_rem;
  assign rem_sh = {rem_r[W-2:0], num_r[W-1]};
  assign trial  = rem_sh - den_r;
  assign sq_rem = {rem_r, num_r[W-1:W-2]};
  assign sqt    = {acc_r[W-3:0], 2'b01};

  logic signed [W-1:0] q_signed;
  assign q_signed = neg_r ? -signed'(acc_r) : signed'(acc_r);

  function automatic logic [W-1:0] fmul(input logic [W-1:0] a, input logic [W-1:0] b);
    return W'(a[QW-1:0] * b[QW-1:0]);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      len_r    <= '0;
      idx_r    <= '0;
      arrive_r <= wsas_pkg::ARRIVE_RST;
      reach_r  <= wsas_pkg::REACH_RST;
      gain_r   <= wsas_pkg::GAIN_RST;
      ovalid_r <= 1'b0;
      busy_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          wsas_pkg::CFG_ARRIVE: arrive_r <= cfg_data;
          wsas_pkg::CFG_REACH:  reach_r  <= cfg_data;
          wsas_pkg::CFG_GAIN:   gain_r   <= cfg_data;
          default: ;
        endcase
      end
      if (out_fire) ovalid_r <= 1'b0;
      if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (state_r == S_SQ1 || state_r == S_SQ2) begin
          num_r <= {num_r[W-3:0], 2'b00};
          if (sq_rem[W-1:0] >= sqt && sq_rem[W+1:W] == 2'b00) begin
            rem_r <= sq_rem[W-1:0] - sqt;
            acc_r <= {acc_r[W-2:0], 1'b1};
          end else begin
            rem_r <= sq_rem[W-1:0];
            acc_r <= {acc_r[W-2:0], 1'b0};
          end
        end else begin
          num_r <= {num_r[W-2:0], 1'b0};
          if (!rem_r[W-1] && rem_sh >= den_r) begin
            rem_r <= trial;
            acc_r <= {acc_r[W-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            acc_r <= {acc_r[W-2:0], 1'b0};
          end
        end
        if (cnt_r == 7'd1) busy_r <= 1'b0;
      end else begin
        unique case (state_r)
          S_IDLE: begin
            if (in_fire) begin
              px_r <= W'(in_ch.pos_x);
              py_r <= W'(in_ch.pos_y);
              vx_r <= W'(in_ch.vel_x);
              vy_r <= W'(in_ch.vel_y);
              ms_r <= in_ch.max_speed;
              case (in_ch.req_type)
                wsas_pkg::REQ_CLEAR: begin
                  len_r <= '0;
                  idx_r <= '0;
                end
                wsas_pkg::REQ_APPEND: begin
                  if (len_r < LW'(MAX_WAYPOINTS)) begin
                    mem_r[len_r[AW-1:0]] <= {in_ch.waypoint_y, in_ch.waypoint_x};
                    len_r <= len_r + 1'b1;
                  end
                end
                wsas_pkg::REQ_STEP: begin
                  if (len_r == '0) begin
                    ox_r <= '0;
                    oy_r <= '0;
                    ohas_r <= 1'b0;
                    oidx_r <= '0;
                    state_r <= S_OUT;
                    ovalid_r <= 1'b1;
                  end else begin
                    state_r <= S_RD;
                  end
                end
                default: ;
              endcase
            end
          end
          S_RD: begin
            rd_r <= mem_r[idx_r];
            state_r <= S_DIFF;
          end
          S_DIFF: begin
            dx_r <= W'(signed'(rd_r[COORD_WIDTH-1:0])) - px_r;
            dy_r <= W'(signed'(rd_r[2*COORD_WIDTH-1:COORD_WIDTH])) - py_r;
            neg_r <= 1'b0;
            state_r <= S_SQ1;
          end
          S_SQ1: begin
            if (cnt_r == '0 && !neg_r) begin
              num_r <= fmul(mag(dx_r), mag(dx_r)) + fmul(mag(dy_r), mag(dy_r));
              rem_r <= '0;
              acc_r <= '0;
              cnt_r <= 7'(SQ);
              busy_r <= 1'b1;
              neg_r <= 1'b1;
            end else begin
              dist_r <= acc_r;
              neg_r <= 1'b0;
              cnt_r <= '0;
              state_r <= S_CHK;
            end
          end
          S_CHK: begin
            if (dist_r < W'(reach_r)) begin
              idx_r <= (LW'(idx_r) + 1'b1 >= len_r) ? '0 : idx_r + 1'b1;
            end
            if (dist_r == '0) begin
              fx_r <= '0;
              fy_r <= '0;
              state_r <= S_SUBV;
            end else begin
              num_r <= fmul(mag(dx_r), W'(ms_r));
              neg_r <= dx_r[W-1];
              den_r <= dist_r;
              rem_r <= '0;
              acc_r <= '0;
              cnt_r <= 7'(W);
              busy_r <= 1'b1;
              state_r <= S_DIVX;
            end
          end
          S_DIVX: begin
            fx_r <= q_signed;
            num_r <= fmul(mag(dy_r), W'(ms_r));
            neg_r <= dy_r[W-1];
            rem_r <= '0;
            acc_r <= '0;
            cnt_r <= 7'(W);
            busy_r <= 1'b1;
            state_r <= S_DIVY;
          end
          S_DIVY: begin
            fy_r <= q_signed;
            state_r <= S_SUBV;
          end
          S_SUBV: begin
            fx_r <= fx_r - vx_r;
            fy_r <= fy_r - vy_r;
            neg_r <= 1'b0;
            cnt_r <= '0;
            state_r <= S_SQ2;
          end
          S_SQ2: begin
            if (fx_r == '0 && fy_r == '0) begin
              state_r <= S_ADX;
            end else if (cnt_r == '0 && !neg_r) begin
              num_r <= fmul(mag(fx_r), mag(fx_r)) + fmul(mag(fy_r), mag(fy_r));
              rem_r <= '0;
              acc_r <= '0;
              cnt_r <= 7'(SQ);
              busy_r <= 1'b1;
              neg_r <= 1'b1;
            end else begin
              fmag_r <= acc_r;
              num_r <= fmul(mag(fx_r), W'(gain_r));
              neg_r <= fx_r[W-1];
              den_r <= acc_r;
              rem_r <= '0;
              acc_r <= '0;
              cnt_r <= 7'(W);
              busy_r <= 1'b1;
              state_r <= S_NDX;
            end
          end
          S_NDX: begin
            fx_r <= q_signed;
            num_r <= fmul(mag(fy_r), W'(gain_r));
            neg_r <= fy_r[W-1];
            den_r <= fmag_r;
            rem_r <= '0;
            acc_r <= '0;
            cnt_r <= 7'(W);
            busy_r <= 1'b1;
            state_r <= S_NDY;
          end
          S_NDY: begin
            fy_r <= q_signed;
            state_r <= S_ADX;
          end
          S_ADX: begin
            if (dist_r < W'(arrive_r)) begin
              num_r <= fmul(mag(fx_r), dist_r);
              neg_r <= fx_r[W-1];
              den_r <= W'(arrive_r);
              rem_r <= '0;
              acc_r <= '0;
              cnt_r <= 7'(W);
              busy_r <= 1'b1;
              state_r <= S_ADY;
            end else begin
              state_r <= S_FIN;
            end
          end
          S_ADY: begin
            fx_r <= q_signed - (vx_r <<< 1);
            num_r <= fmul(mag(fy_r), dist_r);
            neg_r <= fy_r[W-1];
            rem_r <= '0;
            acc_r <= '0;
            cnt_r <= 7'(W);
            busy_r <= 1'b1;
            state_r <= S_ADE;
          end
          S_ADE: begin
            fy_r <= q_signed - (vy_r <<< 1);
            state_r <= S_FIN;
          end
          S_FIN: begin
            ox_r <= sat(fx_r);
            oy_r <= sat(fy_r);
            ohas_r <= 1'b1;
            oidx_r <= IW'(idx_r);
            ovalid_r <= 1'b1;
            state_r <= S_OUT;
          end
          S_OUT: begin
            if (out_fire) state_r <= S_IDLE;
          end
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end
endmodule

/* design/wsas_checker.sv */
module wsas_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_has_path,
  input logic [wsas_pkg::IDX_W-1:0] out_waypoint_index,
  input logic [wsas_pkg::FORCE_W-1:0] out_force_x
);
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_path |-> out_waypoint_index == '0 && out_force_x == '0)
    else $error("empty path result not zero");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");
endmodule

bind waypoint_seek_arrive_steering_unit wsas_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_has_path(out_ch.has_path),
  .out_waypoint_index(out_ch.waypoint_index), .out_force_x(out_ch.force_x));
